>>> rtl/fwlk_pkg.sv
// shared types and constants of the four-level page walker
package fwlk_pkg;

    localparam int unsigned VA_W       = 48;
    localparam int unsigned EADDR_W    = 15;
    localparam int unsigned ENTRY_W    = 64;
    localparam int unsigned FRAME_W    = 40;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned ROOT_W     = 6;
    localparam int unsigned IDX_W      = 9;
    localparam int unsigned FRAME_LSB  = 12;
    localparam int unsigned PRESENT_BIT = 0;
    localparam int unsigned APB_AW     = 3;
    localparam int unsigned APB_DW     = 32;

    localparam logic [1:0] LAST_LEVEL = 2'd3;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_XLATE = 1'b1;

    // register index taken from paddr[2]
    localparam logic REG_ROOT = 1'b0;

    localparam logic [STATUS_W-1:0] STAT_FOUND   = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_OUTSIDE = 3'd5;

    typedef struct packed {
        logic               walk;
        logic [EADDR_W-1:0] addr;
        logic [ENTRY_W-1:0] data;
        logic [VA_W-1:0]    va;
    } t_cmd;

    typedef struct packed {
        logic take;
        logic clearing;
    } t_back_ctl;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_HOLD
    } t_state;

endpackage

>>> rtl/fwlk_ram.sv
// generic single-port-write, registered-read RAM
module fwlk_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/fwlk_front.sv
// front end: accepts items, drops writes beyond the store, queues commands
module fwlk_front #(
    parameter int unsigned TABLE_FRAMES = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    output logic                             o_full,
    input  logic                             i_func,
    input  logic [fwlk_pkg::EADDR_W-1:0]     i_entry_addr,
    input  logic [fwlk_pkg::ENTRY_W-1:0]     i_entry_data,
    input  logic [fwlk_pkg::VA_W-1:0]        i_virt_addr,
    input  fwlk_pkg::t_back_ctl              i_back,
    output logic                             o_cmd_valid,
    output fwlk_pkg::t_cmd                   o_cmd
);

    localparam int unsigned STORE_WORDS = TABLE_FRAMES * 512;

    fwlk_pkg::t_cmd r_q [2];
    logic           r_wptr, n_wptr;
    logic           r_rptr, n_rptr;
    logic [1:0]     r_count, n_count;
    logic           w_accept;
    logic           w_in_range;
    logic           w_keep;
    logic           w_take;

    assign o_full     = (r_count == 2'd2) || i_back.clearing;
    assign w_accept   = i_push && !o_full;
    assign w_in_range = {17'd0, i_entry_addr} < 32'(STORE_WORDS);
    assign w_keep     = w_accept && ((i_func == fwlk_pkg::FUNC_XLATE) || w_in_range);
    assign w_take     = i_back.take && (r_count != 2'd0);

    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rptr];

    always_comb begin
        n_wptr  = r_wptr ^ w_keep;
        n_rptr  = r_rptr ^ w_take;
        n_count = r_count + 2'(w_keep) - 2'(w_take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_keep) begin
            r_q[r_wptr].walk <= (i_func == fwlk_pkg::FUNC_XLATE);
            r_q[r_wptr].addr <= i_entry_addr;
            r_q[r_wptr].data <= i_entry_data;
            r_q[r_wptr].va   <= i_virt_addr;
        end
    end

endmodule

>>> rtl/fwlk_walk.sv
// back end: table store, clearing pass, four-level walk sequencer, result register
module fwlk_walk #(
    parameter int unsigned TABLE_FRAMES = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [fwlk_pkg::ROOT_W-1:0]       i_root,
    input  logic                              i_cmd_valid,
    input  fwlk_pkg::t_cmd                    i_cmd,
    output fwlk_pkg::t_back_ctl               o_back,
    input  logic                              i_pop,
    output logic                              o_empty,
    output logic [fwlk_pkg::STATUS_W-1:0]     o_status,
    output logic [fwlk_pkg::FRAME_W-1:0]      o_frame_number
);

    // only the first 64 frames can ever be written through a 15-bit address
    localparam int unsigned MEM_FRAMES = (TABLE_FRAMES < 64) ? TABLE_FRAMES : 64;
    localparam int unsigned DEPTH      = MEM_FRAMES * 512;
    localparam int unsigned AW         = $clog2(DEPTH);
    localparam int unsigned FAW        = AW - fwlk_pkg::IDX_W;

    localparam logic [fwlk_pkg::FRAME_W-1:0] TABLE_LIM = fwlk_pkg::FRAME_W'(TABLE_FRAMES);
    localparam logic [fwlk_pkg::FRAME_W-1:0] MEM_LIM   = fwlk_pkg::FRAME_W'(MEM_FRAMES);

    fwlk_pkg::t_state r_state, n_state;
    logic [AW-1:0]                    r_clr, n_clr;
    logic [fwlk_pkg::VA_W-1:0]        r_va, n_va;
    logic [1:0]                       r_level, n_level;
    logic                             r_zero, n_zero;
    logic [fwlk_pkg::STATUS_W-1:0]    r_res_status, n_res_status;
    logic [fwlk_pkg::FRAME_W-1:0]     r_res_frame, n_res_frame;
    logic                             r_out_valid;
    logic [fwlk_pkg::STATUS_W-1:0]    r_out_status;
    logic [fwlk_pkg::FRAME_W-1:0]     r_out_frame;

    logic                             w_we;
    logic [AW-1:0]                    w_waddr;
    logic [fwlk_pkg::ENTRY_W-1:0]     w_wdata;
    logic [AW-1:0]                    w_raddr;
    logic [fwlk_pkg::ENTRY_W-1:0]     w_rdata;
    logic [fwlk_pkg::ENTRY_W-1:0]     w_entry;
    logic [fwlk_pkg::FRAME_W-1:0]     w_next_frame;
    logic [fwlk_pkg::FRAME_W-1:0]     w_root;
    logic                             w_slot_free;
    logic                             w_take;
    logic                             w_fin;
    logic [fwlk_pkg::STATUS_W-1:0]    w_fin_status;
    logic [fwlk_pkg::FRAME_W-1:0]     w_fin_frame;
    logic                             w_out_load;

    function automatic logic [fwlk_pkg::IDX_W-1:0] f_idx(
        input logic [fwlk_pkg::VA_W-1:0] va,
        input logic [1:0]                lvl
    );
        case (lvl)
            2'd0:    f_idx = va[47:39];
            2'd1:    f_idx = va[38:30];
            2'd2:    f_idx = va[29:21];
            default: f_idx = va[20:12];
        endcase
    endfunction

    fwlk_ram #(
        .WIDTH (fwlk_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // frames past the writable range always read as a zero entry
    assign w_entry      = r_zero ? '0 : w_rdata;
    assign w_next_frame = w_entry[fwlk_pkg::FRAME_LSB +: fwlk_pkg::FRAME_W];
    assign w_root       = {{(fwlk_pkg::FRAME_W-fwlk_pkg::ROOT_W){1'b0}}, i_root};
    assign w_slot_free  = !r_out_valid || i_pop;

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_va         = r_va;
        n_level      = r_level;
        n_zero       = r_zero;
        n_res_status = r_res_status;
        n_res_frame  = r_res_frame;
        w_we         = 1'b0;
        w_waddr      = r_clr;
        w_wdata      = '0;
        w_raddr      = '0;
        w_take       = 1'b0;
        w_fin        = 1'b0;
        w_fin_status = fwlk_pkg::STAT_FOUND;
        w_fin_frame  = '0;
        w_out_load   = 1'b0;

        case (r_state)
            fwlk_pkg::S_CLEAR: begin
                w_we  = 1'b1;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = fwlk_pkg::S_IDLE;
                end
            end
            fwlk_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    w_take = 1'b1;
                    if (!i_cmd.walk) begin
                        w_we    = 1'b1;
                        w_waddr = i_cmd.addr[AW-1:0];
                        w_wdata = i_cmd.data;
                    end else if (w_root >= TABLE_LIM) begin
                        w_fin        = 1'b1;
                        w_fin_status = fwlk_pkg::STAT_OUTSIDE;
                    end else begin
                        w_raddr = {w_root[FAW-1:0], f_idx(i_cmd.va, 2'd0)};
                        n_zero  = (w_root >= MEM_LIM);
                        n_va    = i_cmd.va;
                        n_level = 2'd0;
                        n_state = fwlk_pkg::S_WALK;
                    end
                end
            end
            fwlk_pkg::S_WALK: begin
                if (!w_entry[fwlk_pkg::PRESENT_BIT]) begin
                    w_fin        = 1'b1;
                    w_fin_status = fwlk_pkg::STATUS_W'(r_level) + 3'd1;
                    n_state      = fwlk_pkg::S_IDLE;
                end else if (r_level == fwlk_pkg::LAST_LEVEL) begin
                    // final page frame is not checked against the store size
                    w_fin       = 1'b1;
                    w_fin_frame = w_next_frame;
                    n_state     = fwlk_pkg::S_IDLE;
                end else if (w_next_frame >= TABLE_LIM) begin
                    w_fin        = 1'b1;
                    w_fin_status = fwlk_pkg::STAT_OUTSIDE;
                    n_state      = fwlk_pkg::S_IDLE;
                end else begin
                    w_raddr = {w_next_frame[FAW-1:0], f_idx(r_va, r_level + 2'd1)};
                    n_zero  = (w_next_frame >= MEM_LIM);
                    n_level = r_level + 2'd1;
                end
            end
            fwlk_pkg::S_HOLD: begin
                if (w_slot_free) begin
                    w_out_load = 1'b1;
                    n_state    = fwlk_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fwlk_pkg::S_IDLE;
            end
        endcase

        // result goes straight to the output slot, or parks until it frees
        if (w_fin) begin
            n_res_status = w_fin_status;
            n_res_frame  = w_fin_frame;
            if (w_slot_free) begin
                w_out_load = 1'b1;
            end else begin
                n_state = fwlk_pkg::S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fwlk_pkg::S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_va         <= n_va;
        r_level      <= n_level;
        r_zero       <= n_zero;
        r_res_status <= n_res_status;
        r_res_frame  <= n_res_frame;
        if (w_out_load) begin
            r_out_status <= n_res_status;
            r_out_frame  <= n_res_frame;
        end
    end

    assign o_back.take     = w_take;
    assign o_back.clearing = (r_state == fwlk_pkg::S_CLEAR);
    assign o_empty         = !r_out_valid;
    assign o_status        = r_out_status;
    assign o_frame_number  = r_out_frame;

endmodule

>>> rtl/four_level_page_walk.sv
// Four-level page-table walker over a local table store of 64-bit entries.
// After reset the store is zeroed by a clearing pass over min(TABLE_FRAMES,64)*512
// entries (32768 at the default), during which full stays high; the root register
// can be written meanwhile. Items pass through a two-entry command queue into the
// walker. A table write gives no result; a write beyond the store is dropped at
// the input. A translation makes four dependent reads of the table RAM, starting
// at the root level, each waiting on its registered read port. The result is
// held in an output register, and the queue keeps taking items while it waits,
// until its two entries are full. Frames past the 64th (only with TABLE_FRAMES
// above 64) cannot be written through the 15-bit entry address and read as not
// present.
module four_level_page_walk #(
    parameter int unsigned TABLE_FRAMES = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fwlk_pkg::APB_AW-1:0]       paddr,
    input  logic [fwlk_pkg::APB_DW-1:0]       pwdata,
    output logic [fwlk_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    input  logic                              push,
    output logic                              full,
    input  logic                              i_func,
    input  logic [fwlk_pkg::EADDR_W-1:0]      i_entry_addr,
    input  logic [fwlk_pkg::ENTRY_W-1:0]      i_entry_data,
    input  logic [fwlk_pkg::VA_W-1:0]         i_virt_addr,
    output logic                              empty,
    input  logic                              pop,
    output logic [fwlk_pkg::STATUS_W-1:0]     o_status,
    output logic [fwlk_pkg::FRAME_W-1:0]      o_frame_number
);

    logic [fwlk_pkg::ROOT_W-1:0] r_root;
    logic                        w_cfg_wr;
    logic                        w_cmd_valid;
    fwlk_pkg::t_cmd              w_cmd;
    fwlk_pkg::t_back_ctl         w_back;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == fwlk_pkg::REG_ROOT)
                    ? {{(fwlk_pkg::APB_DW-fwlk_pkg::ROOT_W){1'b0}}, r_root}
                    : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
        end else if (w_cfg_wr && (paddr[2] == fwlk_pkg::REG_ROOT)) begin
            r_root <= pwdata[fwlk_pkg::ROOT_W-1:0];
        end
    end

    fwlk_front #(
        .TABLE_FRAMES (TABLE_FRAMES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_func       (i_func),
        .i_entry_addr (i_entry_addr),
        .i_entry_data (i_entry_data),
        .i_virt_addr  (i_virt_addr),
        .i_back       (w_back),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd)
    );

    fwlk_walk #(
        .TABLE_FRAMES (TABLE_FRAMES)
    ) u_walk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_root         (r_root),
        .i_cmd_valid    (w_cmd_valid),
        .i_cmd          (w_cmd),
        .o_back         (w_back),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_status       (o_status),
        .o_frame_number (o_frame_number)
    );

    // nothing can be queued while the store is being cleared
    a_clear_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back.clearing |-> !w_cmd_valid)
        else $error("command queued during clearing pass");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status <= fwlk_pkg::STAT_OUTSIDE))
        else $error("result status out of range");

    a_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status != fwlk_pkg::STAT_FOUND)) |-> (o_frame_number == '0))
        else $error("frame number set on a failed walk");

    a_no_take_on_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back.clearing |-> !w_back.take)
        else $error("walker took a command during clearing pass");

endmodule

>>> sim/tb_top.sv
// self-checking testbench for the four-level page walker: table writes, walks, root changes
module tb_top;
    import fwlk_pkg::*;

    localparam int unsigned TABLE_FRAMES  = 64;
    localparam int unsigned STORE_WORDS   = TABLE_FRAMES * 512;
    localparam int unsigned CLK_PERIOD    = 10;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned HOLD_CYCLES   = 250;
    localparam int unsigned WATCHDOG_MAX  = 100000;
    // not present at level 4; one higher for each level down
    localparam logic [STATUS_W-1:0] STAT_ABSENT_TOP = 3'd1;

    typedef struct {
        logic               func;
        logic [EADDR_W-1:0] addr;
        logic [ENTRY_W-1:0] data;
        logic [VA_W-1:0]    va;
    } walk_item_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  frame;
    } xlate_result_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                push = 1'b0;
    logic                full;
    logic                i_func = FUNC_WRITE;
    logic [EADDR_W-1:0]  i_entry_addr = '0;
    logic [ENTRY_W-1:0]  i_entry_data = '0;
    logic [VA_W-1:0]     i_virt_addr = '0;
    logic                empty;
    logic                pop = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [FRAME_W-1:0]  o_frame_number;

    walk_item_t          item_feed_q[$];
    xlate_result_t       xlate_results_q[$];
    logic [VA_W-1:0]     seen_va_q[$];
    logic [ENTRY_W-1:0]  page_store[logic [EADDR_W-1:0]];
    logic [ROOT_W-1:0]   root_cfg = '0;
    walk_item_t          cur_item;
    int                  n_queued = 0;
    int                  n_taken = 0;
    int                  n_errors = 0;
    int                  feed_gap = 0;
    int                  sink_gap = 0;
    int                  quiet_cycles = 0;
    bit                  idle_on = 1'b1;
    logic                sink_hold = 1'b0;

    four_level_page_walk #(
        .TABLE_FRAMES(TABLE_FRAMES)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .push(push),
        .full(full),
        .i_func(i_func),
        .i_entry_addr(i_entry_addr),
        .i_entry_data(i_entry_data),
        .i_virt_addr(i_virt_addr),
        .empty(empty),
        .pop(pop),
        .o_status(o_status),
        .o_frame_number(o_frame_number)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        if (n_errors < 40) $display("mismatch @%0t: %s", $time, msg);
        n_errors++;
    endtask

    function automatic logic [ENTRY_W-1:0] read_store(input logic [EADDR_W-1:0] a);
        return page_store.exists(a) ? page_store[a] : '0;
    endfunction

    // walks the four levels over the mirrored store
    function automatic xlate_result_t translate_va(input logic [VA_W-1:0] va);
        xlate_result_t      r;
        logic [FRAME_W-1:0] frame;
        logic [IDX_W-1:0]   idx;
        logic [ENTRY_W-1:0] e;
        int                 lvl;
        frame = FRAME_W'(root_cfg);
        r.status = STAT_FOUND;
        r.frame = '0;
        for (lvl = 0; lvl < 4; lvl++) begin
            idx = va[VA_W - 1 - IDX_W * lvl -: IDX_W];
            if (frame >= TABLE_FRAMES) begin
                r.status = STAT_OUTSIDE;
                return r;
            end
            e = read_store({frame[ROOT_W-1:0], idx});
            if (!e[PRESENT_BIT]) begin
                r.status = STAT_ABSENT_TOP + STATUS_W'(lvl);
                return r;
            end
            frame = e[FRAME_LSB +: FRAME_W];
        end
        r.frame = frame;
        return r;
    endfunction

    task automatic take_item(input walk_item_t it);
        if (it.func == FUNC_WRITE) begin
            if (32'(it.addr) < STORE_WORDS) page_store[it.addr] = it.data;
        end else begin
            xlate_results_q.push_back(translate_va(it.va));
        end
        n_taken++;
    endtask

    // driver: holds the offered item until the transfer happens
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) take_item(cur_item);
            if (!push || !full) begin
                if (feed_gap != 0) begin
                    feed_gap--;
                    push <= 1'b0;
                end else if (item_feed_q.size() != 0) begin
                    cur_item = item_feed_q.pop_front();
                    i_func <= cur_item.func;
                    i_entry_addr <= cur_item.addr;
                    i_entry_data <= cur_item.data;
                    i_virt_addr <= cur_item.va;
                    push <= 1'b1;
                    if (idle_on && $urandom_range(0, 9) == 0) feed_gap = $urandom_range(1, 15);
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        xlate_result_t want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (xlate_results_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status %0d frame %h",
                                              o_status, o_frame_number));
                end else begin
                    want = xlate_results_q.pop_front();
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                    if (o_frame_number !== want.frame)
                        report_mismatch($sformatf("frame %h, want %h", o_frame_number, want.frame));
                end
            end
            if (sink_hold) begin
                pop <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if (idle_on && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 15);
            end
        end
    end

    // long receiver stall so the walker backs up and raises full
    initial begin
        wait (n_taken >= 60);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic set_root(input logic [ROOT_W-1:0] v);
        logic [APB_DW-1:0] wdata;
        wdata = $urandom;
        wdata[ROOT_W-1:0] = v;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_ROOT, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        root_cfg = v;
    endtask

    task automatic queue_write(input logic [EADDR_W-1:0] addr, input logic [ENTRY_W-1:0] data);
        walk_item_t it;
        it.func = FUNC_WRITE;
        it.addr = addr;
        it.data = data;
        it.va = VA_W'({$urandom, $urandom});
        item_feed_q.push_back(it);
        n_queued++;
    endtask

    task automatic queue_xlate(input logic [VA_W-1:0] va);
        walk_item_t it;
        it.func = FUNC_XLATE;
        it.addr = EADDR_W'($urandom);
        it.data = {$urandom, $urandom};
        it.va = va;
        item_feed_q.push_back(it);
        n_queued++;
        seen_va_q.push_back(va);
        if (seen_va_q.size() > 16) void'(seen_va_q.pop_front());
    endtask

    task automatic queue_entry(input logic [ROOT_W-1:0] tbl, input logic [IDX_W-1:0] idx,
                               input logic [FRAME_W-1:0] nxt, input logic present);
        logic [ENTRY_W-1:0] data;
        data = {$urandom, $urandom};
        data[FRAME_LSB +: FRAME_W] = nxt;
        data[PRESENT_BIT] = present;
        queue_write({tbl, idx}, data);
    endtask

    task automatic queue_directed();
        logic [VA_W-1:0] va;
        queue_xlate('0);                                   // empty store, stops at the top
        queue_entry(6'd0, '1, 40'd1, 1'b1);
        queue_entry(6'd1, '1, 40'd2, 1'b1);
        queue_entry(6'd2, '1, 40'd3, 1'b1);
        queue_write({6'd3, {IDX_W{1'b1}}}, '1);            // large-page bit set, walked anyway
        queue_xlate('1);
        va = '1; va[38:30] = '0; queue_xlate(va);
        va = '1; va[29:21] = '0; queue_xlate(va);
        va = '1; va[20:12] = '0; queue_xlate(va);
        va = '1; va[11:0] = '0; queue_xlate(va);
        // next table far outside the store, then just past it
        queue_entry(6'd0, '0, '1, 1'b1);
        queue_xlate('0);
        queue_entry(6'd2, '0, FRAME_W'(TABLE_FRAMES), 1'b1);
        va = '1; va[29:21] = '0; queue_xlate(va);
        // final page frame zero is still found
        queue_entry(6'd3, '0, '0, 1'b1);
        va = '1; va[20:12] = '0; queue_xlate(va);
        queue_write('1, '0);
        queue_entry(6'd1, '1, 40'd2, 1'b0);                // frame bits set but not present
        queue_xlate('1);
        queue_entry(6'd1, '1, 40'd2, 1'b1);
    endtask

    // builds a chain of tables over a few shared frames, sometimes broken
    task automatic queue_random_walk();
        logic [VA_W-1:0]    va;
        logic [FRAME_W-1:0] tbl;
        logic [FRAME_W-1:0] nxt;
        logic [IDX_W-1:0]   idx;
        int                 lvl;
        int                 pick;
        va = VA_W'({$urandom, $urandom});
        tbl = FRAME_W'(root_cfg);
        for (lvl = 0; lvl < 4; lvl++) begin
            idx = va[VA_W - 1 - IDX_W * lvl -: IDX_W];
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                queue_entry(tbl[ROOT_W-1:0], idx, FRAME_W'({$urandom, $urandom}), 1'b0);
                break;
            end
            if (pick == 1 && lvl < 3) begin
                nxt = FRAME_W'({$urandom, $urandom});
                if (nxt < TABLE_FRAMES) nxt[ROOT_W] = 1'b1;
                queue_entry(tbl[ROOT_W-1:0], idx, nxt, 1'b1);
                break;
            end
            if (lvl < 3) nxt = FRAME_W'($urandom_range(0, 7));
            else nxt = FRAME_W'({$urandom, $urandom});
            queue_entry(tbl[ROOT_W-1:0], idx, nxt, 1'b1);
            tbl = nxt;
        end
        queue_xlate(va);
    endtask

    task automatic run_random(input int n_items);
        int               target;
        logic [VA_W-1:0] va;
        target = n_queued + n_items;
        while (n_queued < target) begin
            case ($urandom_range(0, 9))
                7: begin
                    if (seen_va_q.size() != 0) begin
                        va = seen_va_q[$urandom_range(0, seen_va_q.size() - 1)];
                        va[11:0] = 12'($urandom);
                        if ($urandom_range(0, 1) == 0) va[$urandom_range(12, VA_W - 1)] ^= 1'b1;
                        queue_xlate(va);
                    end
                end
                8: queue_write(EADDR_W'($urandom), {$urandom, $urandom});
                9: queue_xlate(VA_W'({$urandom, $urandom}));
                default: queue_random_walk();
            endcase
        end
    endtask

    // everything handed over and answered, then let trailing writes retire
    task automatic wait_idle();
        while (n_taken != n_queued || xlate_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_root('0);
        queue_directed();
        run_random(145);
        wait_idle();
        set_root('1);
        run_random(145);
        wait_idle();
        set_root(ROOT_W'($urandom_range(1, 62)));
        idle_on = 1'b0;
        run_random(145);
        wait_idle();
        if (n_errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/fwlk_pkg.sv
rtl/fwlk_ram.sv
rtl/fwlk_front.sv
rtl/fwlk_walk.sv
rtl/four_level_page_walk.sv
sim/tb_top.sv
